@@ rtl/bisscan_pkg.sv @@
// Package for the bencode info span scanner: request/result payload types,
// scan modes, status codes and key table. No dependencies.
package bisscan_pkg;

  localparam int DEF_MAX_DEPTH = 255;
  localparam int DEF_LEN_WIDTH = 32;
  localparam int DEF_POS_WIDTH = 32;

  localparam int KEY_LEN = 6;

  localparam logic [7:0] CH_DICT  = 8'h64; // 'd'
  localparam logic [7:0] CH_LIST  = 8'h6c; // 'l'
  localparam logic [7:0] CH_INT   = 8'h69; // 'i'
  localparam logic [7:0] CH_END   = 8'h65; // 'e'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'
  localparam logic [7:0] CH_COLON = 8'h3a; // ':'
  localparam logic [7:0] CH_FOUR  = 8'h34; // '4'

  typedef enum logic [2:0] {
    MODE_SEARCH,
    MODE_TOKEN,
    MODE_INT,
    MODE_LEN,
    MODE_SKIP,
    MODE_DONE,
    MODE_ERR
  } scan_mode_t;

  typedef enum logic [2:0] {
    ST_SEARCHING = 3'd0,
    ST_SCANNING  = 3'd1,
    ST_DONE      = 3'd2,
    ST_BADTOK    = 3'd3,
    ST_TRUNC     = 3'd4,
    ST_NOTFOUND  = 3'd5,
    ST_DEPTH     = 3'd6,
    ST_LENOVF    = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] byte_position;
    logic        in_span;
    logic        span_last;
    status_t     status;
    logic [31:0] span_start;
  } out_res_t;

  // "4:info", indexed by match count
  function automatic logic [7:0] key_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h34; // '4'
      3'd1:    c = 8'h3a; // ':'
      3'd2:    c = 8'h69; // 'i'
      3'd3:    c = 8'h6e; // 'n'
      3'd4:    c = 8'h66; // 'f'
      3'd5:    c = 8'h6f; // 'o'
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/bencode_info_span_scanner.sv @@
// Bencode info span scanner: one byte per request, one result per byte.
// Uses bisscan_pkg for payload types, modes and status codes.
//
// Usage:
//   in_*  : request channel (valid/ready), one buffer byte plus a last-byte mark.
//   out_* : result channel (valid/ready), one result per request: byte offset,
//           in_span / span_last marks for the info value, status, span start.
//   Each request is decoded by a short combinational step that updates the
//   scan state and loads the result register in the same cycle, so a result
//   appears in the cycle after its request is accepted. Throughput is one byte
//   per cycle while results are taken; the limit is the single result register.
//   While the receiver stalls, the result register holds and in_ready drops
//   until the held result is taken; a new request is accepted in the cycle
//   the old result leaves.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   the scanner to key search at offset zero. After a request marked
//   last_byte the scan state returns to the same reset values.
//   Errors (bad token, depth or length overflow) are sticky until the last
//   byte of the buffer.
module bencode_info_span_scanner
  import bisscan_pkg::*;
#(
  parameter int MAX_DEPTH = DEF_MAX_DEPTH,
  parameter int LEN_WIDTH = DEF_LEN_WIDTH,
  parameter int POS_WIDTH = DEF_POS_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_res_t out_data
);

  localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
  localparam int PROD_W  = LEN_WIDTH + 4;
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(MAX_DEPTH);

  scan_mode_t           mode_r, mode_nxt;
  logic [2:0]           key_cnt_r, key_cnt_nxt;
  logic [DEPTH_W-1:0]   depth_r, depth_nxt;
  logic [LEN_WIDTH-1:0] len_r, len_nxt;
  logic [LEN_WIDTH-1:0] skip_r, skip_nxt;
  logic [POS_WIDTH-1:0] pos_r, pos_nxt;
  logic [POS_WIDTH-1:0] start_r, start_nxt;
  status_t              err_r, err_nxt;
  logic                 out_valid_r;
  out_res_t             out_r, res;

  logic                 accept;
  logic [7:0]           b;
  logic                 fin, digit, span, last;
  logic [3:0]           dval;
  logic [PROD_W-1:0]    len_prod;
  logic [LEN_WIDTH-1:0] skip_dec;
  logic [DEPTH_W-1:0]   depth_dec;
  logic [POS_WIDTH-1:0] pos_inc;
  status_t              status;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign b         = in_data.data_byte;
  assign fin       = in_data.last_byte;
  assign digit     = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval      = 4'(b - CH_ZERO);
  // acc * 10 + digit; any bit above LEN_WIDTH means overflow
  assign len_prod  = ({4'b0, len_r} << 3) + ({4'b0, len_r} << 1) + PROD_W'(dval);
  assign skip_dec  = (skip_r != '0) ? skip_r - 1'b1 : skip_r;
  assign depth_dec = depth_r - 1'b1;
  assign pos_inc   = pos_r + 1'b1;

  always_comb begin
    mode_nxt    = mode_r;
    key_cnt_nxt = key_cnt_r;
    depth_nxt   = depth_r;
    len_nxt     = len_r;
    skip_nxt    = skip_r;
    start_nxt   = start_r;
    err_nxt     = err_r;
    span        = 1'b0;
    last        = 1'b0;

    unique case (mode_r)
      MODE_SEARCH: begin
        if (b == key_char(key_cnt_r)) begin
          if (key_cnt_r == 3'(KEY_LEN - 1)) begin
            key_cnt_nxt = '0;
            mode_nxt    = MODE_TOKEN;
            depth_nxt   = '0;
            start_nxt   = pos_inc;
          end else begin
            key_cnt_nxt = key_cnt_r + 1'b1;
          end
        end else begin
          key_cnt_nxt = (b == CH_FOUR) ? 3'd1 : 3'd0;
        end
      end
      MODE_TOKEN: begin
        span = 1'b1;
        if (b == CH_DICT || b == CH_LIST) begin
          if (depth_r >= DEPTH_MAX) begin
            mode_nxt = MODE_ERR;
            err_nxt  = ST_DEPTH;
            span     = 1'b0;
          end else begin
            depth_nxt = depth_r + 1'b1;
          end
        end else if (b == CH_INT) begin
          mode_nxt = MODE_INT;
        end else if (digit) begin
          len_nxt  = LEN_WIDTH'(dval);
          mode_nxt = MODE_LEN;
        end else if (b == CH_END && depth_r != '0) begin
          depth_nxt = depth_dec;
          if (depth_dec == '0) begin
            mode_nxt = MODE_DONE;
            last     = 1'b1;
          end
        end else begin
          mode_nxt = MODE_ERR;
          err_nxt  = ST_BADTOK;
          span     = 1'b0;
        end
      end
      MODE_INT: begin
        span = 1'b1;
        if (b == CH_END) begin
          if (depth_r == '0) begin
            mode_nxt = MODE_DONE;
            last     = 1'b1;
          end else begin
            mode_nxt = MODE_TOKEN;
          end
        end
      end
      MODE_LEN: begin
        span = 1'b1;
        if (digit) begin
          if (len_prod[PROD_W-1:LEN_WIDTH] != 4'd0) begin
            mode_nxt = MODE_ERR;
            err_nxt  = ST_LENOVF;
            span     = 1'b0;
          end else begin
            len_nxt = len_prod[LEN_WIDTH-1:0];
          end
        end else if (b == CH_COLON) begin
          if (len_r == '0) begin
            if (depth_r == '0) begin
              mode_nxt = MODE_DONE;
              last     = 1'b1;
            end else begin
              mode_nxt = MODE_TOKEN;
            end
          end else begin
            skip_nxt = len_r;
            mode_nxt = MODE_SKIP;
          end
        end else begin
          mode_nxt = MODE_ERR;
          err_nxt  = ST_BADTOK;
          span     = 1'b0;
        end
      end
      MODE_SKIP: begin
        span     = 1'b1;
        skip_nxt = skip_dec;
        if (skip_dec == '0) begin
          if (depth_r == '0) begin
            mode_nxt = MODE_DONE;
            last     = 1'b1;
          end else begin
            mode_nxt = MODE_TOKEN;
          end
        end
      end
      MODE_DONE, MODE_ERR: begin
      end
      default: begin
      end
    endcase

    unique case (mode_nxt)
      MODE_SEARCH:                                status = fin ? ST_NOTFOUND : ST_SEARCHING;
      MODE_TOKEN, MODE_INT, MODE_LEN, MODE_SKIP: status = fin ? ST_TRUNC : ST_SCANNING;
      MODE_DONE:                                  status = ST_DONE;
      default:                                    status = err_nxt;
    endcase

    res.byte_position = 32'(pos_r);
    res.in_span       = span;
    res.span_last     = last;
    res.status        = status;
    res.span_start    = 32'(start_nxt);

    pos_nxt = pos_inc;
    // end of buffer: everything back to reset values
    if (fin) begin
      mode_nxt    = MODE_SEARCH;
      key_cnt_nxt = '0;
      depth_nxt   = '0;
      len_nxt     = '0;
      skip_nxt    = '0;
      pos_nxt     = '0;
      start_nxt   = '0;
      err_nxt     = ST_SEARCHING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_SEARCH;
      key_cnt_r   <= '0;
      depth_r     <= '0;
      len_r       <= '0;
      skip_r      <= '0;
      pos_r       <= '0;
      start_r     <= '0;
      err_r       <= ST_SEARCHING;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        mode_r    <= mode_nxt;
        key_cnt_r <= key_cnt_nxt;
        depth_r   <= depth_nxt;
        len_r     <= len_nxt;
        skip_r    <= skip_nxt;
        pos_r     <= pos_nxt;
        start_r   <= start_nxt;
        err_r     <= err_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_r <= res;
    end
  end

endmodule

@@ rtl/bisscan_checker.sv @@
// Port-level checker for the bencode info span scanner, bound to the top level.
// Uses bisscan_pkg for the result payload type and status codes.
module bisscan_checker
  import bisscan_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_res_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // closing byte only ever ends a completed span
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.span_last |-> out_data.in_span && out_data.status == ST_DONE)
    else $error("span_last without completed span");

  // a span byte is never reported with an error or search status
  a_span_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_span |->
      out_data.status == ST_SCANNING || out_data.status == ST_DONE ||
      out_data.status == ST_TRUNC)
    else $error("span byte with bad status");

  // a span byte that reports done must be the closing byte
  a_done_closes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.in_span && out_data.status == ST_DONE |-> out_data.span_last)
    else $error("span byte after completion");

  // a result follows every accepted request
  a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

endmodule

bind bencode_info_span_scanner bisscan_checker u_bisscan_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/testbench.sv @@
// Testbench for bencode_info_span_scanner: directed byte table, then random
// bencoded buffers, each result checked against a cycle-free scan predictor.
// Depends on bisscan_pkg and the scanner RTL.
`timescale 1ns / 100ps

module testbench;
  import bisscan_pkg::*;

  localparam int          MAX_NEST     = DEF_MAX_DEPTH;
  localparam logic [47:0] INFO_KEY     = "4:info";
  localparam int          RANDOM_BYTES = 110;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
    logic       fixed;
    out_res_t   want;
  } step_row_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_res_t out_data;

  bencode_info_span_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted scanner state
  logic [2:0]  key_cnt;
  scan_mode_t  mode;
  int unsigned depth;
  logic [31:0] len_acc;
  logic [31:0] skip_cnt;
  logic [31:0] pos_cnt;
  logic [31:0] start_ofs;
  status_t     err_code;

  out_res_t   pending_results[$];
  logic [7:0] buf_bytes[$];
  int         fails = 0;
  int         bytes_sent = 0;
  int         taken = 0;

  // Directed bytes: fixed rows carry a hand-written result, others use the predictor.
  step_row_t directed_rows [0:28] = '{
    // lone byte, buffer ends while searching
    '{8'h00, 1'b1, 1'b1, '{32'd0, 1'b0, 1'b0, ST_NOTFOUND, 32'd0}},
    // overlapping key start, then an empty string at depth zero, then a byte after done
    '{"4", 1'b0, 1'b0, '0},
    '{"4", 1'b0, 1'b0, '0},
    '{":", 1'b0, 1'b0, '0},
    '{"i", 1'b0, 1'b0, '0},
    '{"n", 1'b0, 1'b0, '0},
    '{"f", 1'b0, 1'b0, '0},
    '{"o", 1'b0, 1'b0, '0},
    '{"0", 1'b0, 1'b0, '0},
    '{":", 1'b0, 1'b1, '{32'd8, 1'b1, 1'b1, ST_DONE, 32'd7}},
    '{8'hff, 1'b1, 1'b1, '{32'd9, 1'b0, 1'b0, ST_DONE, 32'd7}},
    // close at depth zero: bad token wins over truncation
    '{"4", 1'b0, 1'b0, '0},
    '{":", 1'b0, 1'b0, '0},
    '{"i", 1'b0, 1'b0, '0},
    '{"n", 1'b0, 1'b0, '0},
    '{"f", 1'b0, 1'b0, '0},
    '{"o", 1'b0, 1'b0, '0},
    '{"e", 1'b1, 1'b1, '{32'd6, 1'b0, 1'b0, ST_BADTOK, 32'd6}},
    // nested containers with an integer body, cut off while open
    '{"4", 1'b0, 1'b0, '0},
    '{":", 1'b0, 1'b0, '0},
    '{"i", 1'b0, 1'b0, '0},
    '{"n", 1'b0, 1'b0, '0},
    '{"f", 1'b0, 1'b0, '0},
    '{"o", 1'b0, 1'b0, '0},
    '{"d", 1'b0, 1'b0, '0},
    '{"l", 1'b0, 1'b0, '0},
    '{"i", 1'b0, 1'b0, '0},
    '{"-", 1'b0, 1'b0, '0},
    '{"e", 1'b1, 1'b1, '{32'd10, 1'b1, 1'b0, ST_TRUNC, 32'd6}}
  };

  function automatic void clear_scan();
    key_cnt   = '0;
    mode      = MODE_SEARCH;
    depth     = 0;
    len_acc   = '0;
    skip_cnt  = '0;
    pos_cnt   = '0;
    start_ofs = '0;
    err_code  = ST_SEARCHING;
  endfunction

  function automatic void scan_error(input status_t code, inout out_res_t res);
    mode         = MODE_ERR;
    err_code     = code;
    res.in_span  = 1'b0;
  endfunction

  function automatic void close_value(inout out_res_t res);
    if (depth == 0) begin
      mode          = MODE_DONE;
      res.span_last = 1'b1;
    end else begin
      mode = MODE_TOKEN;
    end
  endfunction

  function automatic out_res_t scan_byte(input in_req_t r);
    logic [7:0]  b;
    logic        digit;
    logic [35:0] grown;
    out_res_t    res;
    b = r.data_byte;
    digit = (b >= CH_ZERO) && (b <= CH_NINE);
    res = '0;
    res.byte_position = pos_cnt;
    case (mode)
      MODE_SEARCH: begin
        if (key_cnt < KEY_LEN && b == INFO_KEY[47 - 8 * key_cnt -: 8])
          key_cnt++;
        else
          key_cnt = (b == CH_FOUR) ? 3'd1 : 3'd0;
        if (key_cnt >= KEY_LEN) begin
          key_cnt   = '0;
          mode      = MODE_TOKEN;
          depth     = 0;
          start_ofs = pos_cnt + 32'd1;
        end
      end
      MODE_TOKEN: begin
        res.in_span = 1'b1;
        if (b == CH_DICT || b == CH_LIST) begin
          if (depth >= MAX_NEST) scan_error(ST_DEPTH, res);
          else depth++;
        end else if (b == CH_INT) begin
          mode = MODE_INT;
        end else if (digit) begin
          len_acc = 32'(b - CH_ZERO);
          mode    = MODE_LEN;
        end else if (b == CH_END && depth > 0) begin
          depth--;
          if (depth == 0) begin
            mode          = MODE_DONE;
            res.span_last = 1'b1;
          end
        end else begin
          scan_error(ST_BADTOK, res);
        end
      end
      MODE_INT: begin
        res.in_span = 1'b1;
        if (b == CH_END) close_value(res);
      end
      MODE_LEN: begin
        res.in_span = 1'b1;
        if (digit) begin
          grown = {4'd0, len_acc} * 36'd10 + {28'd0, b - CH_ZERO};
          if (grown > 36'hffff_ffff) scan_error(ST_LENOVF, res);
          else len_acc = grown[31:0];
        end else if (b == CH_COLON) begin
          if (len_acc == 0) begin
            close_value(res);
          end else begin
            skip_cnt = len_acc;
            mode     = MODE_SKIP;
          end
        end else begin
          scan_error(ST_BADTOK, res);
        end
      end
      MODE_SKIP: begin
        res.in_span = 1'b1;
        if (skip_cnt > 0) skip_cnt--;
        if (skip_cnt == 0) close_value(res);
      end
      default: ;
    endcase

    if (mode == MODE_SEARCH)
      res.status = r.last_byte ? ST_NOTFOUND : ST_SEARCHING;
    else if (mode == MODE_DONE)
      res.status = ST_DONE;
    else if (mode == MODE_ERR)
      res.status = err_code;
    else
      res.status = r.last_byte ? ST_TRUNC : ST_SCANNING;
    res.span_start = start_ofs;

    if (r.last_byte) clear_scan();
    else pos_cnt = pos_cnt + 32'd1;
    return res;
  endfunction

  function automatic void field_check(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void check_result(input out_res_t got);
    out_res_t want;
    if (pending_results.size() == 0) begin
      fails++;
      $display("%0t: result with no request pending: %p", $time, got);
    end else begin
      want = pending_results.pop_front();
      field_check("byte_position", want.byte_position, got.byte_position);
      field_check("in_span", 32'(want.in_span), 32'(got.in_span));
      field_check("span_last", 32'(want.span_last), 32'(got.span_last));
      field_check("status", 32'(want.status), 32'(got.status));
      field_check("span_start", want.span_start, got.span_start);
    end
  endfunction

  // ---- buffer builders ----

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) buf_bytes.push_back(s[i]);
  endfunction

  // biased toward bytes that matter to the key matcher and tokenizer
  function automatic logic [7:0] noise_byte();
    string hot;
    hot = "4:infodlie0123456789";
    if ($urandom_range(0, 2) == 0) return hot[$urandom_range(0, hot.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic void put_string();
    int n;
    n = $urandom_range(0, 6);
    if ($urandom_range(0, 7) == 0) buf_bytes.push_back(CH_ZERO);
    put_text($sformatf("%0d", n));
    buf_bytes.push_back(CH_COLON);
    repeat (n) buf_bytes.push_back(8'($urandom_range(0, 255)));
  endfunction

  function automatic void put_value(input int lvl);
    int         kind;
    int         n;
    logic [7:0] c;
    string      num;
    num = "-0123456789";
    kind = $urandom_range(0, (lvl >= 4) ? 1 : 3);
    case (kind)
      0: begin
        buf_bytes.push_back(CH_INT);
        n = $urandom_range(0, 4);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0) begin
            c = 8'($urandom_range(0, 255));
            if (c == CH_END) c = "-";
          end else begin
            c = num[$urandom_range(0, num.len() - 1)];
          end
          buf_bytes.push_back(c);
        end
        buf_bytes.push_back(CH_END);
      end
      1: put_string();
      default: begin
        buf_bytes.push_back(kind == 2 ? CH_LIST : CH_DICT);
        n = $urandom_range(0, 3);
        repeat (n) begin
          if (kind == 3) put_string();
          put_value(lvl + 1);
        end
        buf_bytes.push_back(CH_END);
      end
    endcase
  endfunction

  function automatic void build_buffer();
    int pick;
    int first;
    int cut;
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      repeat ($urandom_range(1, 8)) buf_bytes.push_back(noise_byte());
    end else begin
      repeat ($urandom_range(0, 4)) buf_bytes.push_back(noise_byte());
      put_text("4:info");
      first = buf_bytes.size();
      put_value(0);
      repeat ($urandom_range(0, 3)) buf_bytes.push_back(noise_byte());
      if (pick == 2) begin
        // cut == first ends the buffer on the last key byte
        cut = $urandom_range(first, buf_bytes.size() - 1);
        while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
      end else if (pick == 3) begin
        buf_bytes[$urandom_range(first, buf_bytes.size() - 1)] = 8'($urandom_range(0, 255));
      end
    end
  endfunction

  // ---- request side ----

  task automatic offer(input in_req_t r, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_buffer(input bit burst);
    in_req_t r;
    for (int i = 0; i < buf_bytes.size(); i++) begin
      r.data_byte = buf_bytes[i];
      r.last_byte = (i == buf_bytes.size() - 1);
      offer(r, burst ? 0 : $urandom_range(0, 12));
      pending_results.push_back(scan_byte(r));
      bytes_sent++;
    end
    buf_bytes.delete();
  endtask

  initial begin
    in_req_t  r;
    out_res_t res;
    int       random_from;
    clear_scan();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      r.data_byte = directed_rows[k].data;
      r.last_byte = directed_rows[k].fin;
      offer(r, $urandom_range(0, 12));
      res = scan_byte(r);
      pending_results.push_back(directed_rows[k].fixed ? directed_rows[k].want : res);
    end

    // depth overflow: one container more than the limit allows
    put_text("4:info");
    repeat (MAX_NEST) buf_bytes.push_back($urandom_range(0, 1) ? CH_DICT : CH_LIST);
    put_text("dxe");
    send_buffer(1'b1);
    // length one past the 32-bit range, then the largest legal length
    put_text("4:info4294967296:x");
    send_buffer(1'b0);
    put_text("4:info4294967295:ab");
    send_buffer(1'b0);
    put_text("ab4:info");
    send_buffer(1'b0);

    random_from = bytes_sent;
    while (bytes_sent - random_from < RANDOM_BYTES) begin
      build_buffer();
      send_buffer($urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---- result side ----

  initial begin
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      // two long hold-offs let the result register fill and back up the requests
      if (taken == 60 || taken == 300)
        stall = 150;
      else if ((taken / 32) % 3 == 0)
        stall = 0;
      else
        stall = $urandom_range(0, 12);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
      taken++;
    end
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
